### rtl/keyframe_index_sampled_lookup_macros.svh
// assertion macros for the keyframe index lookup checker
`ifndef KEYFRAME_INDEX_SAMPLED_LOOKUP_MACROS_SVH
`define KEYFRAME_INDEX_SAMPLED_LOOKUP_MACROS_SVH

// same-cycle implication
`define KISL_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kisl check failed");

// next-cycle implication
`define KISL_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kisl check failed");

`endif

### rtl/kisl_pkg.sv
package kisl_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_RANGE = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  localparam logic CFG_FRAME_COUNT = 1'b0;
  localparam logic CFG_SAMPLE_RATE = 1'b1;

  localparam logic [7:0] RATE_RESET = 8'd60;

endpackage

### rtl/kisl_div.sv
module kisl_div #(
  parameter int DW = 45,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CTW = $clog2(DW + 1);

  logic [VW-1:0]  rem_r;
  logic [DW-1:0]  quo_r;
  logic [VW-1:0]  dvs_r;
  logic [CTW-1:0] cnt_r;
  logic           run_r;
  logic           done_r;
  logic [VW:0]    trial;
  logic           fit;

  assign trial = {rem_r, quo_r[DW-1]};
  assign fit   = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CTW'(DW);
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
      end else if (run_r) begin
        rem_r <= VW'(fit ? (trial - {1'b0, dvs_r}) : trial);
        quo_r <= {quo_r[DW-2:0], fit};
        cnt_r <= cnt_r - CTW'(1);
        if (cnt_r == CTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/keyframe_index_sampled_lookup.sv
// keyframe index lookup through a sampled table
// input: an item is taken when start is high and busy is low; cmd selects
//   write keyframe time, build sample table, query index, or nothing
// config: cfg_we writes frame_count (index 0) or sample_rate (index 1)
// output: every item gives one result, out_valid high for one cycle with
//   out_frame_index and out_status; the receiver cannot stall
// write, unused and too-few-keys items answer in the cycle after start
// clamped query: answers from the end keys after reading the first, last and
//   second-last keys; query through the table: one divider pass when not looping,
//   one extra divider pass (the modulo) when looping, then a table read
// build: per sample a multiply, a divider pass unless there is one sample, then
//   one key read per compare from the last key down; the divider is shared, bit-serial
// busy stays high for the whole item for items that leave idle; one item at a time
// reset: frame_count 0, sample_rate 60, table empty; key times and table
//   entries hold no value until written
module keyframe_index_sampled_lookup #(
  parameter int MAX_KEYS    = 64,
  parameter int MAX_SAMPLES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [5:0]         in_key_slot,
  input  logic signed [31:0] in_time_value,
  input  logic               in_looping,
  output logic               out_valid,
  output logic signed [6:0]  out_frame_index,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);
  import kisl_pkg::*;

  localparam int KAW = $clog2(MAX_KEYS);
  localparam int KCW = $clog2(MAX_KEYS + 1);
  localparam int NW  = $clog2(MAX_SAMPLES + 1);
  localparam int TAW = $clog2(MAX_SAMPLES);
  localparam int MBW = (NW > 8) ? NW : 8;
  localparam int PW  = 32 + MBW;

  typedef enum logic [4:0] {
    S_IDLE, S_RDS, S_RDE, S_RDP, S_DUR, S_NMUL, S_NSAT,
    S_MODGO, S_MODW, S_QMUL, S_QDGO, S_QDW, S_QRD, S_QOUT,
    S_BMUL, S_BDGO, S_BDW, S_SRD, S_SCMP
  } state_t;

  state_t state_r;

  logic [6:0] frame_count_r;
  logic [7:0] sample_rate_r;

  logic [1:0]         cmd_r;
  logic signed [31:0] time_r;
  logic               loop_r;
  logic [KCW-1:0]     cnt_r;
  logic signed [31:0] start_t_r;
  logic signed [31:0] end_t_r;
  logic signed [31:0] pen_r;
  logic signed [32:0] dur_r;
  logic [NW-1:0]      siu_r;
  logic [NW-1:0]      n_r;
  logic [PW-1:0]      prod_r;
  logic [31:0]        rel_r;
  logic               xneg_r;
  logic [32:0]        xabs_r;
  logic [NW-1:0]      i_r;
  logic [KCW-1:0]     j_r;
  logic signed [31:0] ts_r;
  logic               out_valid_r;
  logic signed [6:0]  out_fi_r;
  logic [1:0]         out_st_r;

  logic signed [31:0] key_mem [MAX_KEYS];
  logic signed [31:0] key_rd_r;
  logic [KAW-1:0]     tbl_mem [MAX_SAMPLES];
  logic [KAW-1:0]     tbl_rd_r;

  logic [KCW-1:0]     act_cnt;
  logic [KCW-1:0]     cntm2;
  logic               key_we;
  logic [KAW-1:0]     key_waddr;
  logic [KAW-1:0]     key_raddr;
  logic               tbl_we;
  logic [TAW-1:0]     tbl_raddr;
  logic [KAW-1:0]     tbl_wdata;
  logic [31:0]        mul_a;
  logic [MBW-1:0]     mul_b;
  logic [PW-1:0]      mul_p;
  logic               dur_np;
  logic [PW-1:0]      nraw;
  logic [NW-1:0]      n_now;
  logic signed [32:0] xdiff;
  logic               div_go;
  logic [PW-1:0]      div_dvd;
  logic [31:0]        div_dvs;
  logic               div_done;
  logic [PW-1:0]      div_quo;
  logic [31:0]        div_rem;
  logic               hit;
  logic               accept;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign act_cnt = KCW'((32'(frame_count_r) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS)
                                                             : 32'(frame_count_r));
  assign cntm2   = cnt_r - KCW'(2);

  assign key_we    = accept && (in_cmd == CMD_WRITE) && (32'(in_key_slot) < 32'(MAX_KEYS));
  assign key_waddr = KAW'(32'(in_key_slot));

  always_comb begin
    unique case (state_r)
      S_RDE:   key_raddr = KAW'(cnt_r - KCW'(1));
      S_RDP:   key_raddr = KAW'(cntm2);
      S_SRD:   key_raddr = KAW'(j_r);
      default: key_raddr = '0;
    endcase
  end

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_QMUL: begin
        mul_a = rel_r;
        mul_b = MBW'(n_r);
      end
      S_BMUL: begin
        mul_a = dur_r[31:0];
        mul_b = MBW'(i_r);
      end
      default: begin
        mul_a = dur_r[31:0];
        mul_b = MBW'(sample_rate_r);
      end
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign dur_np = dur_r[32] || (dur_r == '0);
  assign nraw   = prod_r >> 16;
  assign n_now  = dur_np ? '0 : ((nraw > PW'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : NW'(nraw));
  assign xdiff  = 33'(time_r) - 33'(start_t_r);

  always_comb begin
    div_go  = 1'b0;
    div_dvd = prod_r;
    div_dvs = dur_r[31:0];
    unique case (state_r)
      S_MODGO: begin
        div_go  = 1'b1;
        div_dvd = PW'(xabs_r);
      end
      S_QDGO: div_go = 1'b1;
      S_BDGO: begin
        div_go  = 1'b1;
        div_dvs = 32'(n_r - NW'(1));
      end
      default: div_go = 1'b0;
    endcase
  end

  kisl_div #(.DW(PW), .VW(32)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign hit       = ts_r >= key_rd_r;
  assign tbl_we    = (state_r == S_SCMP) && (hit || (j_r == '0));
  assign tbl_wdata = hit ? ((j_r >= cntm2) ? KAW'(cntm2) : KAW'(j_r)) : '0;
  assign tbl_raddr = TAW'(div_quo);

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= in_time_value;
    end
    key_rd_r <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[TAW'(i_r)] <= tbl_wdata;
    end
    tbl_rd_r <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      sample_rate_r <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[6:0];
        CFG_SAMPLE_RATE: sample_rate_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      siu_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r  <= in_cmd;
            time_r <= in_time_value;
            loop_r <= in_looping;
            cnt_r  <= act_cnt;
            unique case (in_cmd)
              CMD_BUILD, CMD_QUERY: begin
                if (act_cnt < KCW'(2)) begin
                  out_valid_r <= 1'b1;
                  out_fi_r    <= (in_cmd == CMD_QUERY) ? -7'sd1 : 7'sd0;
                  out_st_r    <= ST_FEW;
                end else begin
                  state_r <= S_RDS;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
                out_fi_r    <= 7'sd0;
                out_st_r    <= ST_OK;
              end
            endcase
          end
        end
        S_RDS: state_r <= S_RDE;
        S_RDE: begin
          start_t_r <= key_rd_r;
          state_r   <= S_RDP;
        end
        S_RDP: begin
          end_t_r <= key_rd_r;
          state_r <= S_DUR;
        end
        S_DUR: begin
          pen_r   <= key_rd_r;
          dur_r   <= 33'(end_t_r) - 33'(start_t_r);
          state_r <= S_NMUL;
        end
        S_NMUL: begin
          prod_r  <= mul_p;
          xneg_r  <= xdiff[32];
          xabs_r  <= xdiff[32] ? 33'(-xdiff) : 33'(xdiff);
          state_r <= S_NSAT;
        end
        S_NSAT: begin
          n_r <= n_now;
          if (cmd_r == CMD_BUILD) begin
            siu_r <= n_now;
            i_r   <= '0;
            if (n_now == '0) begin
              out_valid_r <= 1'b1;
              out_fi_r    <= 7'sd0;
              out_st_r    <= ST_OK;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_BMUL;
            end
          end else if (loop_r) begin
            if (dur_np) begin
              out_valid_r <= 1'b1;
              out_fi_r    <= -7'sd1;
              out_st_r    <= ST_RANGE;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_MODGO;
            end
          end else begin
            priority if (time_r <= start_t_r) begin
              out_valid_r <= 1'b1;
              out_fi_r    <= 7'sd0;
              out_st_r    <= ST_OK;
              state_r     <= S_IDLE;
            end else if (time_r >= pen_r) begin
              out_valid_r <= 1'b1;
              out_fi_r    <= 7'(cntm2);
              out_st_r    <= ST_OK;
              state_r     <= S_IDLE;
            end else if (dur_np) begin
              out_valid_r <= 1'b1;
              out_fi_r    <= -7'sd1;
              out_st_r    <= ST_RANGE;
              state_r     <= S_IDLE;
            end else begin
              rel_r   <= xabs_r[31:0];
              state_r <= S_QMUL;
            end
          end
        end
        S_MODGO: state_r <= S_MODW;
        S_MODW: begin
          if (div_done) begin
            rel_r   <= (xneg_r && (div_rem != '0)) ? (dur_r[31:0] - div_rem) : div_rem;
            state_r <= S_QMUL;
          end
        end
        S_QMUL: begin
          prod_r  <= mul_p;
          state_r <= S_QDGO;
        end
        S_QDGO: state_r <= S_QDW;
        S_QDW: begin
          if (div_done) begin
            if (div_quo >= PW'(siu_r)) begin
              out_valid_r <= 1'b1;
              out_fi_r    <= -7'sd1;
              out_st_r    <= ST_RANGE;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_QRD;
            end
          end
        end
        S_QRD: state_r <= S_QOUT;
        S_QOUT: begin
          out_valid_r <= 1'b1;
          out_fi_r    <= 7'(tbl_rd_r);
          out_st_r    <= ST_OK;
          state_r     <= S_IDLE;
        end
        S_BMUL: begin
          prod_r <= mul_p;
          if (n_r == NW'(1)) begin
            ts_r    <= start_t_r;
            j_r     <= cnt_r - KCW'(1);
            state_r <= S_SRD;
          end else begin
            state_r <= S_BDGO;
          end
        end
        S_BDGO: state_r <= S_BDW;
        S_BDW: begin
          if (div_done) begin
            ts_r    <= start_t_r + $signed(div_quo[31:0]);
            j_r     <= cnt_r - KCW'(1);
            state_r <= S_SRD;
          end
        end
        S_SRD: state_r <= S_SCMP;
        S_SCMP: begin
          if (hit || (j_r == '0)) begin
            if (i_r == n_r - NW'(1)) begin
              out_valid_r <= 1'b1;
              out_fi_r    <= 7'sd0;
              out_st_r    <= ST_OK;
              state_r     <= S_IDLE;
            end else begin
              i_r     <= i_r + NW'(1);
              state_r <= S_BMUL;
            end
          end else begin
            j_r     <= j_r - KCW'(1);
            state_r <= S_SRD;
          end
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_index = out_fi_r;
  assign out_status      = out_st_r;

endmodule

### rtl/kisl_checker.sv
`include "keyframe_index_sampled_lookup_macros.svh"

module kisl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic signed [6:0] out_frame_index,
  input logic [1:0]        out_status
);
  import kisl_pkg::*;

  // an accepted item either answers at once or holds busy
  `KISL_AST_NEXT(a_accept_progress, start && !busy, out_valid || busy)
  // no result while an item is still in work
  `KISL_AST_NOW(a_no_result_busy, out_valid, !busy)
  `KISL_AST_NOW(a_range_index, out_valid && (out_status == ST_RANGE), out_frame_index == -7'sd1)
  `KISL_AST_NOW(a_status_code, out_valid, out_status != ST_UNUSED)

endmodule

bind keyframe_index_sampled_lookup kisl_checker u_kisl_checker (.*);
